### hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared definitions for the preamble framed deframer
// Widths, register indexes, reset values and the structs that pass between
// the parser and the top level.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Payload bytes carried by one frame, kept inside 1..8.
  localparam int PAYLOAD_BYTES = 8;
  localparam int PB_EFF        = (PAYLOAD_BYTES < 1) ? 1 :
                                 ((PAYLOAD_BYTES > 8) ? 8 : PAYLOAD_BYTES);

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int LEN_W       = 4;
  localparam int STORE_DEPTH = 8;
  localparam int IDX_W       = 3;
  localparam int PAYLOAD_W   = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_VALUE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_LENGTH = 1'b1;

  localparam logic [BYTE_W-1:0] PREAMBLE_VALUE_RST  = 8'h55;
  localparam logic [LEN_W-1:0]  PREAMBLE_LENGTH_RST = 4'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] preamble_value;
    logic [LEN_W-1:0]  preamble_length;
  } psd_cfg_t;

  // valid is high while the parser waits for a checksum byte: the next
  // accepted beat then yields this result.
  typedef struct packed {
    logic                 valid;
    logic [PAYLOAD_W-1:0] payload;
    logic                 checksum_ok;
  } psd_result_t;

endpackage

### hdl/psd_if.sv
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if: valid-ready channels of the deframer
// The input channel carries one received byte per beat, the result channel
// one decoded frame per beat.
// ----------------------------------------------------------------------------
interface psd_in_if;
  logic                      valid;
  logic                      ready;
  logic [psd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psd_out_if;
  logic                         valid;
  logic                         ready;
  logic [psd_pkg::PAYLOAD_W-1:0] payload;
  logic                         checksum_ok;

  modport source (output valid, output payload, output checksum_ok, input ready);
  modport sink   (input valid, input payload, input checksum_ok, output ready);
endinterface

### hdl/psd_parser.sv
// ----------------------------------------------------------------------------
// psd_parser: frame parser state machine
// Hunts for the preamble, stores and sums the payload bytes and checks the
// checksum byte. Presents the result of the current beat combinationally.
// ----------------------------------------------------------------------------
module psd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        beat,
  input  logic [psd_pkg::BYTE_W-1:0]  rx_byte,
  input  psd_pkg::psd_cfg_t           cfg,
  output psd_pkg::psd_result_t        result
);
  import psd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_CSUM = 2'd2
  } phase_t;

  localparam logic [CNT_W-1:0] PB_CNT = CNT_W'(PB_EFF);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] store_r [STORE_DEPTH];
  logic              store_we;

  logic [LEN_W-1:0]  need;
  logic [CNT_W-1:0]  seen_inc;
  logic [CNT_W-1:0]  idx_inc;

  // A zero length behaves as a single preamble byte.
  assign need     = (cfg.preamble_length == '0) ? LEN_W'(1) : cfg.preamble_length;
  assign seen_inc = seen_r + CNT_W'(1);
  assign idx_inc  = idx_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    store_we  = 1'b0;
    unique case (phase_r)
      PH_DATA: begin
        store_we = 1'b1;
        sum_nxt  = sum_r + rx_byte;
        idx_nxt  = idx_inc;
        if (idx_inc >= PB_CNT) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        phase_nxt = PH_HUNT;
        seen_nxt  = '0;
        idx_nxt   = '0;
        sum_nxt   = '0;
      end
      default: begin
        // Hunting; the unused phase code hunts as well.
        if (rx_byte == cfg.preamble_value) begin
          seen_nxt = seen_inc;
          if (seen_inc >= need) begin
            phase_nxt = PH_DATA;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end
        end else begin
          phase_nxt = PH_HUNT;
          seen_nxt  = '0;
          idx_nxt   = '0;
          sum_nxt   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      seen_r  <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else if (beat) begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Payload bytes need no reset: each one is written before it is read.
  always_ff @(posedge clk) begin
    if (beat && store_we) begin
      store_r[idx_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    result.valid       = (phase_r == PH_CSUM);
    result.checksum_ok = (rx_byte == sum_r);
    result.payload     = '0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (k < PB_EFF) begin
        result.payload[k*BYTE_W +: BYTE_W] = store_r[k];
      end
    end
  end

endmodule

### hdl/preamble_sum_checked_deframer.sv
// ----------------------------------------------------------------------------
// preamble_sum_checked_deframer: preamble framed receiver with byte checksum
// Finds frames in a byte stream, collects their payload and checks the
// additive checksum that follows it.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one received byte per beat. The block hunts for a
// run of preamble bytes (value and length set through the configuration
// port), then stores the payload bytes and sums them modulo 256. The byte
// after the payload is the checksum; it produces one beat on the result
// channel with the payload (first byte in the low bits) and a pass flag.
// The input takes one byte per cycle while ready is high. Each byte goes through
// the parser in the cycle it is accepted; a checksum byte's result appears in
// the output register in the cycle after its acceptance.
// Only a checksum byte needs room in the output register. While a result
// waits and the receiver stalls, preamble and payload bytes are still taken;
// ready drops only when a checksum byte is due and the output is still full.
// Reset restores the preamble value to 0x55 and the length to 4, empties the
// output register and puts the parser back to hunting. Configuration writes
// take effect for the next accepted byte and are meant for an idle block.
// ----------------------------------------------------------------------------
module preamble_sum_checked_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  psd_in_if.sink                         in_bus,
  psd_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import psd_pkg::*;

  psd_cfg_t             cfg_r;
  psd_result_t          result;
  logic                 beat;
  logic                 out_valid_r;
  logic [PAYLOAD_W-1:0] out_payload_r;
  logic                 out_ok_r;
  logic                 out_free;

  // The output register has room if it is empty or drains in this cycle.
  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !result.valid || out_free;
  assign beat         = in_bus.valid && in_bus.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_value  <= PREAMBLE_VALUE_RST;
      cfg_r.preamble_length <= PREAMBLE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PREAMBLE_VALUE:  cfg_r.preamble_value  <= cfg_wdata[BYTE_W-1:0];
        CFG_PREAMBLE_LENGTH: cfg_r.preamble_length <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  psd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .rx_byte (in_bus.rx_byte),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Output register: loaded by a checksum byte, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && result.valid) begin
      out_payload_r <= result.payload;
      out_ok_r      <= result.checksum_ok;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.payload     = out_payload_r;
  assign out_bus.checksum_ok = out_ok_r;

endmodule

### dv/tb_preamble_sum_checked_deframer.sv
// ----------------------------------------------------------------------------
// tb_preamble_sum_checked_deframer: self-checking bench for the deframer
// Feeds byte streams made mostly of well-formed frames, mixed with broken
// preambles, long preamble runs, cut-off frames and line noise, over a range
// of preamble values and lengths. A behavioral predictor follows every
// accepted byte and queues the frame each checksum byte should deliver; the
// result channel is checked beat by beat against that queue. Both sides of
// the handshake idle at random, and once the receiver holds off long enough
// for the block to back up and stall its input.
// ----------------------------------------------------------------------------
module tb_preamble_sum_checked_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  // Idle behavior of either side of the handshake, chosen per phase.
  typedef enum int {
    IDLE_NONE,    // back-to-back beats
    IDLE_FULL,    // a random gap after every beat
    IDLE_SPARSE   // mostly back-to-back, now and then a long gap
  } idle_mode_t;

  // Parser phases of the predictor. The unused fourth code behaves as a hunt.
  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_PAYLOAD  = 2'd1,
    PH_CHECKSUM = 2'd2
  } frame_phase_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic                 checksum_ok;
  } frame_result_t;

  localparam int BYTES_PER_PHASE = 130;
  localparam int RANDOM_PHASES   = 10;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  psd_in_if  in_bus ();
  psd_out_if out_bus ();

  preamble_sum_checked_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered, and frames the block still owes us.
  logic [BYTE_W-1:0] rx_pending[$];
  frame_result_t     frames_due[$];

  int         mismatch_count = 0;
  int         queued_bytes   = 0;
  idle_mode_t src_idle_mode  = IDLE_SPARSE;
  idle_mode_t snk_idle_mode  = IDLE_SPARSE;
  int         src_wait       = 0;
  int         snk_wait       = 0;
  logic       in_fire        = 1'b0;
  logic       out_fire       = 1'b0;
  logic       hold_request   = 1'b0;
  logic       hold_off       = 1'b0;

  // Predictor state: its own copy of the registers and of the parser.
  logic [BYTE_W-1:0] cfg_value;
  logic [LEN_W-1:0]  cfg_length;
  frame_phase_t      phase_q;
  logic [CNT_W-1:0]  run_count;
  logic [3:0]        fill_idx;
  logic [BYTE_W-1:0] byte_store [STORE_DEPTH];
  logic [BYTE_W-1:0] byte_sum;

  // Stimulus side view of the current framing, used to build frames.
  logic [BYTE_W-1:0] stim_value;
  int                stim_need;

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 18);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [PAYLOAD_W-1:0] got,
                                 input logic [PAYLOAD_W-1:0] want);
    $display("MISMATCH at %0t: %s, got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic restart_hunt();
    phase_q   = PH_HUNT;
    run_count = '0;
    fill_idx  = '0;
    byte_sum  = '0;
  endtask

  // Advance the predicted parser by one accepted byte. A checksum byte
  // queues the frame that the block has to deliver for it.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0]     need;
    logic [PAYLOAD_W-1:0] word;
    frame_result_t        frame;
    case (phase_q)
      PH_PAYLOAD: begin
        byte_store[fill_idx[IDX_W-1:0]] = b;
        byte_sum = byte_sum + b;
        fill_idx = fill_idx + 4'd1;
        if (fill_idx >= PB_EFF) phase_q = PH_CHECKSUM;
      end
      PH_CHECKSUM: begin
        word = '0;
        for (int k = 0; k < PB_EFF; k++) word[8*k +: 8] = byte_store[k];
        frame.payload     = word;
        frame.checksum_ok = (b == byte_sum);
        frames_due.push_back(frame);
        restart_hunt();
      end
      default: begin
        // A zero length counts as one, so a single match opens a frame.
        if (b == cfg_value) begin
          need      = (cfg_length == 0) ? 4'd1 : cfg_length;
          run_count = run_count + 4'd1;
          if (run_count >= need) begin
            phase_q  = PH_PAYLOAD;
            fill_idx = '0;
            byte_sum = '0;
          end
        end else begin
          restart_hunt();
        end
      end
    endcase
  endtask

  // Monitor. Register writes and accepted input beats update the predictor;
  // every accepted result beat is compared with the oldest queued frame.
  // Inputs are handled before outputs so a same-edge result would still
  // find its expectation in place.
  always @(posedge clk) begin
    in_fire  <= rst_n && in_bus.valid && in_bus.ready;
    out_fire <= rst_n && out_bus.valid && out_bus.ready;
    if (!rst_n) begin
      cfg_value  = PREAMBLE_VALUE_RST;
      cfg_length = PREAMBLE_LENGTH_RST;
      restart_hunt();
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PREAMBLE_VALUE) cfg_value = cfg_wdata;
        else if (cfg_index == CFG_PREAMBLE_LENGTH) cfg_length = cfg_wdata[LEN_W-1:0];
      end
      if (in_bus.valid && in_bus.ready) deframe_byte(in_bus.rx_byte);
      if (out_bus.valid && out_bus.ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result beat with no frame pending", out_bus.payload, '0);
        end else begin
          if (out_bus.payload !== frames_due[0].payload)
            report_mismatch("payload", out_bus.payload, frames_due[0].payload);
          if (out_bus.checksum_ok !== frames_due[0].checksum_ok)
            report_mismatch("checksum_ok", PAYLOAD_W'(out_bus.checksum_ok),
                            PAYLOAD_W'(frames_due[0].checksum_ok));
          void'(frames_due.pop_front());
        end
      end
    end
  end

  // Sender. A beat stays on the bus until it is taken; after each beat the
  // gap drawn for it runs out before the next byte is offered.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (src_wait > 0) begin
        in_bus.valid <= 1'b0;
        src_wait--;
      end else if (rx_pending.size() > 0) begin
        in_bus.rx_byte <= rx_pending.pop_front();
        in_bus.valid   <= 1'b1;
        src_wait = draw_wait(src_idle_mode);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver. A fresh stall is drawn after every result beat; a long
  // hold-off from its own process overrides everything.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_fire) snk_wait = draw_wait(snk_idle_mode);
      if (hold_off) begin
        out_bus.ready <= 1'b0;
      end else if (snk_wait > 0) begin
        out_bus.ready <= 1'b0;
        snk_wait--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off. While it lasts the sender keeps offering frames,
  // so the output register fills and the block has to stall its input.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("preamble_sum_checked_deframer test failed");
    $finish;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    rx_pending.push_back(b);
    queued_bytes++;
  endtask

  // Any byte except the current preamble value.
  function automatic logic [BYTE_W-1:0] other_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    return (b == stim_value) ? ~b : b;
  endfunction

  // A frame with preamble_n preamble bytes, random payload and a checksum
  // that is right unless good is low.
  task automatic push_frame(input int preamble_n, input bit good);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    repeat (preamble_n) push_byte(stim_value);
    repeat (PB_EFF) begin
      b = BYTE_W'($urandom_range(0, 255));
      sum = sum + b;
      push_byte(b);
    end
    push_byte(good ? sum : sum + BYTE_W'($urandom_range(1, 255)));
  endtask

  // Wait until every byte is taken and every frame delivered, then let the
  // block settle on bytes that left no result behind.
  task automatic drain();
    while (rx_pending.size() != 0 || in_bus.valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_framing(input logic [BYTE_W-1:0] value, input logic [LEN_W-1:0] len);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    write_reg(CFG_PREAMBLE_VALUE, value);
    // The upper nibble of a length write carries junk that must be dropped.
    write_reg(CFG_PREAMBLE_LENGTH, {junk, len});
    stim_value = value;
    stim_need  = (len == 0) ? 1 : int'(len);
  endtask

  initial begin : stimulus
    int                phase_start;
    int                pick;
    int                cut;
    logic [BYTE_W-1:0] value_pick;
    logic [LEN_W-1:0]  len_pick;

    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    stim_value     = PREAMBLE_VALUE_RST;
    stim_need      = int'(PREAMBLE_LENGTH_RST);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset framing: an all-ones payload whose sum wraps,
    // then a preamble run broken by a foreign byte.
    repeat (4) push_byte(8'h55);
    repeat (PB_EFF) push_byte(8'hFF);
    push_byte(8'hF8);
    push_byte(8'h55);
    push_byte(8'h55);
    push_byte(8'h00);
    drain();

    // Zero preamble length on value zero: one zero byte opens the frame, an
    // all-zero payload follows, and the checksum is off by one.
    set_framing(8'h00, 4'd0);
    push_byte(8'h00);
    repeat (PB_EFF) push_byte(8'h00);
    push_byte(8'h01);

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        1:       begin value_pick = 8'hFF; len_pick = 4'd15; end
        2:       begin value_pick = 8'h00; len_pick = 4'd1;  end
        3:       begin value_pick = 8'hAA; len_pick = 4'd0;  end
        default: begin
          value_pick = BYTE_W'($urandom_range(0, 255));
          len_pick   = LEN_W'($urandom_range(0, 15));
        end
      endcase
      set_framing(value_pick, len_pick);

      if (ph == PRESSURE_PHASE) begin
        src_idle_mode = IDLE_NONE;
        snk_idle_mode = IDLE_NONE;
        hold_request  = 1'b1;
      end else begin
        src_idle_mode = idle_mode_t'($urandom_range(0, 2));
        snk_idle_mode = idle_mode_t'($urandom_range(0, 2));
      end

      // Mostly well-formed frames; the rest overlong preambles, broken
      // preambles, frames cut short and plain noise.
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < BYTES_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          push_frame(stim_need, $urandom_range(0, 3) != 0);
        end else if (pick < 83) begin
          // Extra preamble bytes past the count land in the payload.
          push_frame(stim_need + $urandom_range(1, 3), $urandom_range(0, 1));
        end else if (pick < 91) begin
          repeat ($urandom_range(0, stim_need - 1)) push_byte(stim_value);
          push_byte(other_byte());
        end else if (pick < 96) begin
          cut = $urandom_range(0, PB_EFF - 1);
          repeat (stim_need) push_byte(stim_value);
          repeat (cut) push_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
        end
      end
    end

    // Everything offered; wait out the frames still owed, within a bound.
    while (rx_pending.size() != 0 || in_bus.valid) @(posedge clk);
    for (int n = 0; n < 5000 && frames_due.size() != 0; n++) @(posedge clk);
    if (frames_due.size() != 0)
      report_mismatch("frames never delivered", PAYLOAD_W'(frames_due.size()), '0);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("preamble_sum_checked_deframer test passed");
    end else begin
      $display("preamble_sum_checked_deframer test failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/psd_pkg.sv
hdl/psd_if.sv
hdl/psd_parser.sv
hdl/preamble_sum_checked_deframer.sv
dv/tb_preamble_sum_checked_deframer.sv
